// ===== hdl/csvfs_pkg.sv =====
// Shared types and constants for the CSV field splitter.
// No dependencies; used by every module under hdl/.
package csvfs_pkg;

  localparam int ROW_BITS = 32;
  localparam int COL_BITS = 16;
  localparam int LEN_BITS = 16;
  localparam int BYTE_BITS = 8;

  localparam logic [BYTE_BITS-1:0] CH_CR = 8'd13;
  localparam logic [BYTE_BITS-1:0] CH_LF = 8'd10;
  localparam logic [BYTE_BITS-1:0] DELIM_RESET = 8'd44;

  typedef enum logic [1:0] {
    PH_LINE_START  = 2'd0,
    PH_FIELD_START = 2'd1,
    PH_FIELD_VALUE = 2'd2,
    PH_LINE_END    = 2'd3
  } phase_t;

  typedef enum logic [0:0] {
    KIND_CONTENT   = 1'b0,
    KIND_FIELD_END = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [BYTE_BITS-1:0] byte_value;
    logic [ROW_BITS-1:0]  row_index;
    logic [COL_BITS-1:0]  col_index;
    logic [LEN_BITS-1:0]  field_length;
  } result_t;

endpackage

// ===== hdl/csvfs_in_reg.sv =====
// Input register stage of the CSV field splitter: holds one byte request.
// Depends on csvfs_pkg.
module csvfs_in_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [csvfs_pkg::BYTE_BITS-1:0] in_byte_in,
  input  logic                            take,
  output logic                            valid_q,
  output logic [csvfs_pkg::BYTE_BITS-1:0] byte_q
);

  logic                            valid_r;
  logic                            valid_nxt;
  logic [csvfs_pkg::BYTE_BITS-1:0] byte_r;

  assign in_ready = !valid_r || take;
  assign valid_q  = valid_r;
  assign byte_q   = byte_r;

  always_comb begin
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_in;
    end
  end

endmodule

// ===== hdl/csvfs_step.sv =====
// Per-byte parse step: line phase, row/column/length counters and result build.
// Depends on csvfs_pkg.
module csvfs_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  logic [csvfs_pkg::BYTE_BITS-1:0] byte_in,
  input  logic [csvfs_pkg::BYTE_BITS-1:0] delimiter,
  output logic                            res_valid,
  output csvfs_pkg::result_t              res
);

  csvfs_pkg::phase_t               phase_r, phase_nxt;
  logic [csvfs_pkg::ROW_BITS-1:0]  row_r, row_nxt;
  logic [csvfs_pkg::COL_BITS-1:0]  col_r, col_nxt;
  logic [csvfs_pkg::LEN_BITS-1:0]  len_r, len_nxt;

  logic                            is_brk;
  logic                            is_dlm;
  logic                            in_field;
  logic [csvfs_pkg::ROW_BITS-1:0]  row_inc;

  assign is_brk  = (byte_in == csvfs_pkg::CH_CR) || (byte_in == csvfs_pkg::CH_LF);
  assign is_dlm  = (byte_in == delimiter);
  assign row_inc = row_r + csvfs_pkg::ROW_BITS'(1);

  // Byte is handled as part of a field unless it is a break at line start/end.
  always_comb begin
    unique case (phase_r)
      csvfs_pkg::PH_LINE_START,
      csvfs_pkg::PH_LINE_END:    in_field = !is_brk;
      csvfs_pkg::PH_FIELD_START,
      csvfs_pkg::PH_FIELD_VALUE: in_field = 1'b1;
      default:                   in_field = 1'b1;
    endcase
  end

  // Next phase
  always_comb begin
    if (!in_field) begin
      phase_nxt = csvfs_pkg::PH_LINE_END;
    end else if (is_dlm) begin
      phase_nxt = csvfs_pkg::PH_FIELD_START;
    end else if (is_brk) begin
      phase_nxt = csvfs_pkg::PH_LINE_END;
    end else begin
      phase_nxt = csvfs_pkg::PH_FIELD_VALUE;
    end
  end

  // Counters and result
  always_comb begin
    logic [csvfs_pkg::LEN_BITS-1:0] len_v;

    row_nxt = row_r;
    col_nxt = col_r;
    len_v   = len_r;
    unique case (phase_r)
      csvfs_pkg::PH_LINE_START: begin
        row_nxt = row_inc;
        col_nxt = is_brk ? '1 : '0;
        len_v   = '0;
      end
      csvfs_pkg::PH_LINE_END: begin
        if (!is_brk) begin
          row_nxt = row_inc;
          col_nxt = '0;
          len_v   = '0;
        end
      end
      csvfs_pkg::PH_FIELD_START: begin
        col_nxt = col_r + csvfs_pkg::COL_BITS'(1);
        len_v   = '0;
      end
      default: begin
      end
    endcase

    res_valid        = in_field;
    res.row_index    = row_nxt;
    res.col_index    = col_nxt;
    if (is_dlm || is_brk) begin
      res.kind         = csvfs_pkg::KIND_FIELD_END;
      res.byte_value   = '0;
      res.field_length = len_v;
      len_nxt          = '0;
    end else begin
      res.kind         = csvfs_pkg::KIND_CONTENT;
      res.byte_value   = byte_in;
      res.field_length = '0;
      len_nxt          = (len_v == '1) ? len_v : len_v + csvfs_pkg::LEN_BITS'(1);
    end
    if (!in_field) begin
      len_nxt = len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csvfs_pkg::PH_LINE_START;
      row_r   <= '1;
      col_r   <= '1;
      len_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== hdl/csvfs_out_reg.sv =====
// Result register of the CSV field splitter; drives the output channel.
// Depends on csvfs_pkg.
module csvfs_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic                            res_valid,
  input  csvfs_pkg::result_t              res,
  output logic                            space,
  output logic                            out_valid,
  input  logic                            out_ready,
  output csvfs_pkg::result_t              out_res
);

  logic               valid_r;
  logic               valid_nxt;
  csvfs_pkg::result_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    if (load) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== hdl/csv_field_splitter_top.sv =====
// CSV field splitter, unquoted: one byte request in, zero or one result out.
// An accepted byte passes the input register, then the result register, before its result is valid.
// Throughput: one byte per cycle; the step logic takes the held byte whenever
// the result register is free or being drained in the same cycle.
// Reset (rst_n low, synchronous): line-start phase, row/column all ones,
// length zero, delimiter back to ',', both stages empty.
module csv_field_splitter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [csvfs_pkg::BYTE_BITS-1:0] cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [csvfs_pkg::BYTE_BITS-1:0] in_byte_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [csvfs_pkg::BYTE_BITS-1:0] out_byte_value,
  output logic [csvfs_pkg::ROW_BITS-1:0]  out_row_index,
  output logic [csvfs_pkg::COL_BITS-1:0]  out_col_index,
  output logic [csvfs_pkg::LEN_BITS-1:0]  out_field_length
);

  logic [csvfs_pkg::BYTE_BITS-1:0] delim_r;
  logic                            held_valid;
  logic [csvfs_pkg::BYTE_BITS-1:0] held_byte;
  logic                            space;
  logic                            take;
  logic                            res_valid;
  csvfs_pkg::result_t              res;
  csvfs_pkg::result_t              out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= csvfs_pkg::DELIM_RESET;
    end else if (cfg_wr_en) begin
      delim_r <= cfg_wr_data;
    end
  end

  assign take = held_valid && space;

  csvfs_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte_in (in_byte_in),
    .take       (take),
    .valid_q    (held_valid),
    .byte_q     (held_byte)
  );

  csvfs_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (take),
    .byte_in   (held_byte),
    .delimiter (delim_r),
    .res_valid (res_valid),
    .res       (res)
  );

  csvfs_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_byte_value   = out_res.byte_value;
  assign out_row_index    = out_res.row_index;
  assign out_col_index    = out_res.col_index;
  assign out_field_length = out_res.field_length;

  // A content result never carries a length; a field end never carries a byte.
  a_content_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == csvfs_pkg::KIND_CONTENT) |-> out_field_length == '0)
    else $error("content result with nonzero length");

  a_end_byte : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == csvfs_pkg::KIND_FIELD_END) |-> out_byte_value == '0)
    else $error("field-end result with nonzero byte");

  // Back-pressure on the input only while a byte is held and cannot move on.
  a_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> held_valid && out_valid && !out_ready)
    else $error("input stalled without cause");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for csv_field_splitter_top: directed rows, then random CSV traffic.
// Depends on csvfs_pkg (hdl/csvfs_pkg.sv) and the splitter RTL; nothing else.
module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEG_ITEMS = 128;

  typedef enum {ROW_PRED, ROW_NONE, ROW_RES, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                       how;
    logic [csvfs_pkg::BYTE_BITS-1:0] val;
    csvfs_pkg::result_t              res;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [csvfs_pkg::BYTE_BITS-1:0] cfg_wr_data;
  logic                            in_valid;
  logic                            in_ready;
  logic [csvfs_pkg::BYTE_BITS-1:0] in_byte_in;
  logic                            out_valid;
  logic                            out_ready;
  logic                            out_kind;
  logic [csvfs_pkg::BYTE_BITS-1:0] out_byte_value;
  logic [csvfs_pkg::ROW_BITS-1:0]  out_row_index;
  logic [csvfs_pkg::COL_BITS-1:0]  out_col_index;
  logic [csvfs_pkg::LEN_BITS-1:0]  out_field_length;

  // splitter state as the predictor sees it
  csvfs_pkg::phase_t               line_ph = csvfs_pkg::PH_LINE_START;
  logic [csvfs_pkg::ROW_BITS-1:0]  row_cnt = '1;
  logic [csvfs_pkg::COL_BITS-1:0]  col_cnt = '1;
  logic [csvfs_pkg::LEN_BITS-1:0]  len_cnt = '0;
  logic [csvfs_pkg::BYTE_BITS-1:0] cur_delim = csvfs_pkg::DELIM_RESET;

  csvfs_pkg::result_t owed[$];
  dir_row_t           dir_rows[$];
  csvfs_pkg::result_t head_res;

  int  cycles = 0;
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  results_seen = 0;
  int  field_ends_seen = 0;
  int  delim_writes = 0;
  int  long_max = 40;
  int  sink_wait = 0;
  bit  src_quiet = 1'b0;
  bit  sink_quiet = 1'b0;

  csv_field_splitter_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte_value   (out_byte_value),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_field_length (out_field_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the predicted state by one byte; returns 1 when the byte yields a result.
  function automatic bit split_step(input logic [csvfs_pkg::BYTE_BITS-1:0] b,
                                    output csvfs_pkg::result_t r);
    bit brk;
    brk = (b == csvfs_pkg::CH_CR) || (b == csvfs_pkg::CH_LF);
    r = '0;
    case (line_ph)
      csvfs_pkg::PH_LINE_START: begin
        row_cnt = row_cnt + csvfs_pkg::ROW_BITS'(1);
        col_cnt = '1;
        if (brk) begin
          line_ph = csvfs_pkg::PH_LINE_END;
          return 1'b0;
        end
        col_cnt = '0;
        len_cnt = '0;
      end
      csvfs_pkg::PH_LINE_END: begin
        if (brk) return 1'b0;
        row_cnt = row_cnt + csvfs_pkg::ROW_BITS'(1);
        col_cnt = '0;
        len_cnt = '0;
      end
      csvfs_pkg::PH_FIELD_START: begin
        col_cnt = col_cnt + csvfs_pkg::COL_BITS'(1);
        len_cnt = '0;
      end
      default: ;
    endcase
    r.row_index = row_cnt;
    r.col_index = col_cnt;
    // inside a field the delimiter wins over a line break
    if (b == cur_delim) begin
      r.kind = csvfs_pkg::KIND_FIELD_END;
      r.field_length = len_cnt;
      len_cnt = '0;
      line_ph = csvfs_pkg::PH_FIELD_START;
    end else if (brk) begin
      r.kind = csvfs_pkg::KIND_FIELD_END;
      r.field_length = len_cnt;
      len_cnt = '0;
      line_ph = csvfs_pkg::PH_LINE_END;
    end else begin
      r.kind = csvfs_pkg::KIND_CONTENT;
      r.byte_value = b;
      if (len_cnt != '1) len_cnt = len_cnt + csvfs_pkg::LEN_BITS'(1);
      line_ph = csvfs_pkg::PH_FIELD_VALUE;
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(4, long_max);
  endfunction

  function automatic void add_row(input row_kind_t how,
                                  input logic [csvfs_pkg::BYTE_BITS-1:0] v,
                                  input csvfs_pkg::kind_t k = csvfs_pkg::KIND_CONTENT,
                                  input logic [csvfs_pkg::BYTE_BITS-1:0] bv = '0,
                                  input logic [csvfs_pkg::ROW_BITS-1:0] row = '0,
                                  input logic [csvfs_pkg::COL_BITS-1:0] col = '0,
                                  input logic [csvfs_pkg::LEN_BITS-1:0] len = '0);
    dir_row_t e;
    e.how = how;
    e.val = v;
    e.res = '{k, bv, row, col, len};
    dir_rows.push_back(e);
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    mismatches++;
  endtask

  // Sends one byte request; called at a clock edge, returns at the accepting edge.
  task automatic send_byte(input logic [csvfs_pkg::BYTE_BITS-1:0] b, input row_kind_t how,
                           input csvfs_pkg::result_t typed);
    int gap;
    bit has;
    csvfs_pkg::result_t pred;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
    has = split_step(b, pred);
    if (how == ROW_RES) owed.push_back(typed);
    else if (how == ROW_PRED && has) owed.push_back(pred);
  endtask

  // Delimiter changes only with the pipe empty; absorbed bytes may still be in flight.
  task automatic write_delim(input logic [csvfs_pkg::BYTE_BITS-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (owed.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_delim = v;
    delim_writes++;
  endtask

  task automatic run_segment(input logic [csvfs_pkg::BYTE_BITS-1:0] d);
    int i;
    int r;
    logic [csvfs_pkg::BYTE_BITS-1:0] b;
    write_delim(d);
    src_quiet = ($urandom_range(0, 3) == 0);
    sink_quiet = ($urandom_range(0, 3) == 0);
    for (i = 0; i < SEG_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) b = csvfs_pkg::BYTE_BITS'($urandom_range(0, 255));
      else if (r < 75) b = d;
      else if (r < 85) b = csvfs_pkg::CH_CR;
      else if (r < 95) b = csvfs_pkg::CH_LF;
      else b = {csvfs_pkg::BYTE_BITS{r[0]}};
      send_byte(b, ROW_PRED, '0);
      // hold the sender until every owed result is out
      if (i == SEG_ITEMS / 2 || $urandom_range(0, 99) == 0) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (owed.size() != 0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (sink_wait > 0) begin
      out_ready <= 1'b0;
      sink_wait--;
    end else begin
      out_ready <= 1'b1;
      sink_wait = pick_gap(sink_quiet);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind=%0d byte=0x%0h row=%0d col=%0d len=%0d",
                 $time, out_kind, out_byte_value, out_row_index, out_col_index,
                 out_field_length);
        mismatches++;
      end else begin
        head_res = owed.pop_front();
        if (head_res.kind == csvfs_pkg::KIND_FIELD_END) field_ends_seen++;
        if (out_kind !== head_res.kind)
          flag_field("kind", 32'(head_res.kind), 32'(out_kind));
        if (out_byte_value !== head_res.byte_value)
          flag_field("byte_value", 32'(head_res.byte_value), 32'(out_byte_value));
        if (out_row_index !== head_res.row_index)
          flag_field("row_index", head_res.row_index, out_row_index);
        if (out_col_index !== head_res.col_index)
          flag_field("col_index", 32'(head_res.col_index), 32'(out_col_index));
        if (out_field_length !== head_res.field_length)
          flag_field("field_length", 32'(head_res.field_length), 32'(out_field_length));
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results still owed", cycles, owed.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int i;
    logic [csvfs_pkg::BYTE_BITS-1:0] seg_delim [9];

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_byte_in = '0;
    out_ready = 1'b0;

    // leading blank line, then extremes, empty fields and line-end runs
    add_row(ROW_NONE, csvfs_pkg::CH_CR);
    add_row(ROW_NONE, csvfs_pkg::CH_LF);
    add_row(ROW_RES, 8'h61, csvfs_pkg::KIND_CONTENT, 8'h61, 1, 0, 0);
    add_row(ROW_RES, 8'h00, csvfs_pkg::KIND_CONTENT, 8'h00, 1, 0, 0);
    add_row(ROW_RES, 8'hFF, csvfs_pkg::KIND_CONTENT, 8'hFF, 1, 0, 0);
    add_row(ROW_RES, csvfs_pkg::DELIM_RESET, csvfs_pkg::KIND_FIELD_END, 0, 1, 0, 3);
    add_row(ROW_RES, csvfs_pkg::DELIM_RESET, csvfs_pkg::KIND_FIELD_END, 0, 1, 1, 0);
    add_row(ROW_RES, csvfs_pkg::CH_CR, csvfs_pkg::KIND_FIELD_END, 0, 1, 2, 0);
    add_row(ROW_NONE, csvfs_pkg::CH_LF);
    add_row(ROW_NONE, csvfs_pkg::CH_CR);
    add_row(ROW_PRED, 8'h78);
    add_row(ROW_PRED, csvfs_pkg::CH_LF);
    // CR as separator: line break wins in a line end, delimiter wins in a field
    add_row(ROW_CFG, csvfs_pkg::CH_CR);
    add_row(ROW_NONE, csvfs_pkg::CH_CR);
    add_row(ROW_PRED, 8'h62);
    add_row(ROW_RES, csvfs_pkg::CH_CR, csvfs_pkg::KIND_FIELD_END, 0, 3, 0, 1);
    add_row(ROW_RES, csvfs_pkg::CH_CR, csvfs_pkg::KIND_FIELD_END, 0, 3, 1, 0);
    add_row(ROW_RES, csvfs_pkg::CH_LF, csvfs_pkg::KIND_FIELD_END, 0, 3, 2, 0);
    add_row(ROW_PRED, csvfs_pkg::DELIM_RESET);
    add_row(ROW_CFG, 8'h00);
    add_row(ROW_RES, 8'h00, csvfs_pkg::KIND_FIELD_END, 0, 4, 0, 1);
    add_row(ROW_PRED, 8'hFF);
    add_row(ROW_CFG, 8'hFF);
    add_row(ROW_RES, 8'hFF, csvfs_pkg::KIND_FIELD_END, 0, 4, 1, 1);
    add_row(ROW_PRED, csvfs_pkg::CH_CR);
    add_row(ROW_CFG, csvfs_pkg::CH_LF);
    add_row(ROW_NONE, csvfs_pkg::CH_CR);
    add_row(ROW_NONE, csvfs_pkg::CH_LF);
    add_row(ROW_PRED, 8'h71);
    add_row(ROW_RES, csvfs_pkg::CH_LF, csvfs_pkg::KIND_FIELD_END, 0, 5, 0, 1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[n]) begin
      if (dir_rows[n].how == ROW_CFG) write_delim(dir_rows[n].val);
      else send_byte(dir_rows[n].val, dir_rows[n].how, dir_rows[n].res);
    end

    seg_delim = '{csvfs_pkg::DELIM_RESET, 8'h3B, 8'h09, 8'h7C, csvfs_pkg::CH_CR,
                  csvfs_pkg::CH_LF, 8'h00, 8'hFF, 8'h00};
    seg_delim[8] = csvfs_pkg::BYTE_BITS'($urandom_range(0, 255));
    for (i = 0; i < 9; i++) run_segment(seg_delim[i]);

    in_valid <= 1'b0;
    do @(posedge clk); while (owed.size() != 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes over %0d delimiter settings; checked %0d results, %0d field ends.",
             bytes_sent, delim_writes, results_seen, field_ends_seen);
    $display("Covered blank lines, empty fields, break runs and break-valued separators.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== csv_field_splitter_top.f =====
hdl/csvfs_pkg.sv
hdl/csvfs_in_reg.sv
hdl/csvfs_step.sv
hdl/csvfs_out_reg.sv
hdl/csv_field_splitter_top.sv
tb/tb_top.sv
